// ----- rtl/core/sot_pkg.sv -----
// Package for the segment offset translator.
// Holds function codes, the loadable type and the controller/datapath structs.
// No dependencies.
package sot_pkg;

  localparam int unsigned FuncW = 2;

  localparam logic [FuncW-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_XLATE  = 2'd2;

  localparam logic [31:0] LOADABLE_TYPE = 32'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted item
    logic exec;        // run clear or add, or form a zero result
    logic scan_start;  // reset the scan index to the first entry
    logic scan_step;   // advance the scan by one entry
    logic set_miss;    // translate ended without a match
    logic finish;      // form the translated address of the match
    logic push;        // move the result into the output register
  } sot_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_xlate;    // captured item is a translate
    logic can_scan;    // image base is nonzero and the table is not empty
    logic ent_valid;   // entry under compare lies below the fill count
    logic ent_hit;     // entry under compare holds the query offset
  } sot_sts_t;

endpackage

// ----- rtl/core/sot_in_if.sv -----
// Input channel of the segment offset translator.
// Carries one table or translate item; depends on nothing.
interface sot_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] seg_type;
  logic [63:0] seg_offset;
  logic [63:0] seg_filesz;
  logic [63:0] seg_vaddr;
  logic [63:0] file_offset;

  modport source (output valid, func, seg_type, seg_offset, seg_filesz, seg_vaddr,
                  file_offset, input ready);
  modport sink (input valid, func, seg_type, seg_offset, seg_filesz, seg_vaddr,
                file_offset, output ready);
endinterface

// ----- rtl/core/sot_out_if.sv -----
// Result channel of the segment offset translator.
// Carries one result item; depends on nothing.
interface sot_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] vaddr;
  logic        hit;
  logic        overflow;

  modport source (output valid, vaddr, hit, overflow, input ready);
  modport sink (input valid, vaddr, hit, overflow, output ready);
endinterface

// ----- rtl/core/sot_cfg_if.sv -----
// Configuration write channel of the segment offset translator.
// Carries the image base register value; depends on nothing.
interface sot_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] image_base;

  modport source (output valid, image_base, input ready);
  modport sink (input valid, image_base, output ready);
endinterface

// ----- rtl/core/segment_offset_translator_unit.sv -----
// Top level of the segment offset translator.
// Instantiates sot_ctrl and sot_dp; uses sot_pkg and the sot_*_if interfaces.
//
//   Channel  Direction  Payload                                         Handshake
//   in_i     sink       func, seg_type, seg_offset, seg_filesz,         valid/ready
//                       seg_vaddr, file_offset
//   cfg_i    sink       image_base                                      valid/ready
//   out_o    source     vaddr, hit, overflow                            valid/ready
//
// One item is worked on at a time. A clear or add item, and a translate with a zero
// image base or an empty table, goes from the execute state to the push state and then
// into the output register. A translate item scans the table in load order until it
// matches an entry or passes the fill count, then goes through the add state on a match;
// the table is read one entry per cycle through its single read port.
// Reset clears the fill count, the image base and the controller; table entries
// keep no reset and only entries below the fill count are ever compared.
// A result waiting in the output register does not block acceptance of the next
// item; only a second finished result stalls until the first one is taken.
module segment_offset_translator_unit #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  sot_in_if.sink    in_i,
  sot_cfg_if.sink   cfg_i,
  sot_out_if.source out_o
);

  sot_pkg::sot_cmd_t cmd;
  sot_pkg::sot_sts_t sts;

  // The image base register can always take a write.
  assign cfg_i.ready = 1'b1;

  // The controller sequences each item: capture, execute or scan, then hand
  // the result to the output register once it is free.
  sot_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the segment table, the compare and add stages of the
  // scan, the result register and the output register.
  sot_dp #(
    .MaxSegments (MAX_SEGMENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .func_i           (in_i.func),
    .seg_type_i       (in_i.seg_type),
    .seg_offset_i     (in_i.seg_offset),
    .seg_filesz_i     (in_i.seg_filesz),
    .seg_vaddr_i      (in_i.seg_vaddr),
    .file_offset_i    (in_i.file_offset),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_image_base_i (cfg_i.image_base),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .vaddr_o          (out_o.vaddr),
    .hit_o            (out_o.hit),
    .overflow_o       (out_o.overflow)
  );

`ifndef SYNTH
  // The block works on one item at a time, so it is busy right after an accept.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while an item is still in progress");

  // A translate never reports overflow, and an add never reports a hit.
  a_hit_ovf_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.hit && out_o.overflow))
    else $error("result carries both hit and overflow");

  // Every result without a hit carries a zero address.
  a_miss_zero_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.hit) |-> (out_o.vaddr == 64'd0))
    else $error("result without hit has a nonzero address");
`endif

endmodule

// ----- rtl/core/sot_ctrl.sv -----
// Controller state machine of the segment offset translator.
// Depends on sot_pkg for the command and status structs.
module sot_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sot_pkg::sot_sts_t sts_i,
  output sot_pkg::sot_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN0 = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_ADD   = 3'd4;
  localparam logic [2:0] ST_PUSH  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts_i.is_xlate && sts_i.can_scan) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN0;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = ST_PUSH;
        end
      end
      ST_SCAN0: begin
        cmd_o.scan_step = 1'b1;
        state_d         = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.scan_step = 1'b1;
        if (!sts_i.ent_valid) begin
          cmd_o.set_miss = 1'b1;
          state_d        = ST_PUSH;
        end else if (sts_i.ent_hit) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/core/sot_dp.sv -----
// Datapath of the segment offset translator: item capture, segment table,
// scan pipeline and result registers. Depends on sot_pkg.
module sot_dp #(
  parameter int unsigned MaxSegments = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        func_i,
  input  logic [31:0]       seg_type_i,
  input  logic [63:0]       seg_offset_i,
  input  logic [63:0]       seg_filesz_i,
  input  logic [63:0]       seg_vaddr_i,
  input  logic [63:0]       file_offset_i,
  input  logic              cfg_valid_i,
  input  logic [63:0]       cfg_image_base_i,
  input  sot_pkg::sot_cmd_t cmd_i,
  output sot_pkg::sot_sts_t sts_o,
  output logic [63:0]       vaddr_o,
  output logic              hit_o,
  output logic              overflow_o
);

  localparam int unsigned IdxW  = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CntW  = $clog2(MaxSegments + 1);
  localparam int unsigned ScanW = $clog2(MaxSegments + 2);

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] stop;
    logic [63:0] addr;
  } entry_t;

  // Captured item.
  logic [1:0]  func_q;
  logic [31:0] type_q;
  logic [63:0] off_q, size_q, va_q, qry_q;

  logic [63:0]     base_q;
  logic [CntW-1:0] count_q;
  entry_t          mem_q [MaxSegments];

  logic [ScanW-1:0] scan_idx_q, ent_idx_q;
  logic [IdxW-1:0]  rd_addr;
  entry_t           ent_q;
  logic [63:0]      diff_q, part_q;

  logic [63:0] res_vaddr_q, out_vaddr_q;
  logic        res_hit_q, out_hit_q, res_ovf_q, out_ovf_q;

  logic is_add_load, full, do_write;

  assign is_add_load = (func_q == sot_pkg::FUNC_ADD) && (type_q == sot_pkg::LOADABLE_TYPE);
  assign full        = (count_q >= CntW'(MaxSegments));
  assign do_write    = cmd_i.exec && is_add_load && !full;
  assign rd_addr     = (scan_idx_q < ScanW'(MaxSegments)) ? scan_idx_q[IdxW-1:0] : '0;

  assign sts_o.is_xlate  = (func_q == sot_pkg::FUNC_XLATE);
  assign sts_o.can_scan  = (base_q != 64'd0) && (count_q != '0);
  assign sts_o.ent_valid = (ent_idx_q < ScanW'(count_q));
  assign sts_o.ent_hit   = (qry_q >= ent_q.start) && (qry_q < ent_q.stop);

  assign vaddr_o    = out_vaddr_q;
  assign hit_o      = out_hit_q;
  assign overflow_o = out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= 64'd0;
      count_q    <= '0;
      scan_idx_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_image_base_i;
      end
      if (cmd_i.exec && (func_q == sot_pkg::FUNC_CLEAR)) begin
        count_q <= '0;
      end else if (do_write) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.scan_start) begin
        scan_idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + ScanW'(1);
      end
    end
  end

  // Table write and registered table read.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[count_q[IdxW-1:0]] <= '{start: off_q, stop: off_q + size_q, addr: va_q};
    end
    ent_q     <= mem_q[rd_addr];
    ent_idx_q <= scan_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      type_q <= seg_type_i;
      off_q  <= seg_offset_i;
      size_q <= seg_filesz_i;
      va_q   <= seg_vaddr_i;
      qry_q  <= file_offset_i;
    end
    if (cmd_i.scan_step) begin
      diff_q <= qry_q - ent_q.start;
      part_q <= base_q + ent_q.addr;
    end
    if (cmd_i.exec || cmd_i.set_miss) begin
      res_vaddr_q <= 64'd0;
      res_hit_q   <= 1'b0;
      res_ovf_q   <= cmd_i.exec && is_add_load && full;
    end else if (cmd_i.finish) begin
      res_vaddr_q <= part_q + diff_q;
      res_hit_q   <= 1'b1;
      res_ovf_q   <= 1'b0;
    end
    if (cmd_i.push) begin
      out_vaddr_q <= res_vaddr_q;
      out_hit_q   <= res_hit_q;
      out_ovf_q   <= res_ovf_q;
    end
  end

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for segment_offset_translator_unit.
// Depends on sot_pkg and the sot_in_if, sot_cfg_if and sot_out_if interfaces in rtl/core.
// Drives table and translate items, predicts every result and compares them field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Function code 3 is not decoded by the block; it must come back as an all-zero result.
  localparam logic [sot_pkg::FuncW-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned NUM_SEGS = 16;
  // Cycles in which no channel moves an item before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS = 740;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [sot_pkg::FuncW-1:0] func;
    logic [31:0]               seg_type;
    logic [63:0]               seg_offset;
    logic [63:0]               seg_filesz;
    logic [63:0]               seg_vaddr;
    logic [63:0]               file_offset;
  } xlate_req_t;

  typedef struct packed {
    logic [63:0] vaddr;
    logic        hit;
    logic        overflow;
  } xlate_rsp_t;

  logic clk_i;
  logic rst_ni;

  sot_in_if  in_if ();
  sot_cfg_if cfg_if ();
  sot_out_if out_if ();

  segment_offset_translator_unit #(
    .MAX_SEGMENTS(NUM_SEGS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .cfg_i (cfg_if),
    .out_o (out_if)
  );

  // Predictor state: our own copy of the segment table and the image base.
  logic [63:0] seg_lo [NUM_SEGS];
  logic [63:0] seg_hi [NUM_SEGS];
  logic [63:0] seg_va [NUM_SEGS];
  int unsigned seg_fill;
  logic [63:0] load_base;

  // Results the block still owes us, oldest first.
  xlate_rsp_t pending_results[$];

  int unsigned errors;
  int unsigned useful_items;   // items the block acts on (not ignored ones)
  int unsigned quiet_cycles;   // cycles since any channel last moved an item

  // Sender pacing: burst length left, and a switch that turns gaps off.
  int unsigned burst_left;
  bit          gapless;

  // Receiver pacing: a long hold-off requested by a test, and the current stall pattern.
  int unsigned hold_cycles;
  int unsigned rx_mode;
  int unsigned rx_mode_left;
  bit          rx_toggle;

  // Clock: 10 ns period, starting low.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Applies one accepted item to the predictor state and returns the result it must produce.
  // The scan walks the filled entries in load order and stops at the first one that
  // holds the offset; an entry whose end wrapped below its start can never match.
  function automatic xlate_rsp_t predict_outcome(input xlate_req_t req);
    xlate_rsp_t rsp;
    bit found;
    rsp = '0;
    found = 1'b0;
    case (req.func)
      sot_pkg::FUNC_CLEAR: begin
        seg_fill = 0;
      end
      sot_pkg::FUNC_ADD: begin
        if (req.seg_type == sot_pkg::LOADABLE_TYPE) begin
          if (seg_fill >= NUM_SEGS) begin
            rsp.overflow = 1'b1;
          end else begin
            seg_lo[seg_fill] = req.seg_offset;
            seg_hi[seg_fill] = req.seg_offset + req.seg_filesz;
            seg_va[seg_fill] = req.seg_vaddr;
            seg_fill++;
          end
        end
      end
      sot_pkg::FUNC_XLATE: begin
        if (load_base != 64'd0) begin
          for (int unsigned i = 0; i < seg_fill && !found; i++) begin
            if (req.file_offset >= seg_lo[i] && req.file_offset < seg_hi[i]) begin
              rsp.vaddr = load_base + seg_va[i] + (req.file_offset - seg_lo[i]);
              rsp.hit   = 1'b1;
              found     = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  // Monitor: everything is sampled at the rising edge, before the block's own
  // registers update. Config writes update the predicted base, accepted input
  // items queue a prediction, and accepted results are checked against the oldest one.
  // The same process runs the hang watchdog.
  xlate_req_t seen_req;
  xlate_rsp_t want_rsp;
  bit         moved;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_if.valid && cfg_if.ready) begin
        load_base = cfg_if.image_base;
        moved = 1'b1;
      end
      if (in_if.valid && in_if.ready) begin
        seen_req.func        = in_if.func;
        seen_req.seg_type    = in_if.seg_type;
        seen_req.seg_offset  = in_if.seg_offset;
        seen_req.seg_filesz  = in_if.seg_filesz;
        seen_req.seg_vaddr   = in_if.seg_vaddr;
        seen_req.file_offset = in_if.file_offset;
        pending_results.push_back(predict_outcome(seen_req));
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected: vaddr %h hit %b overflow %b",
                 out_if.vaddr, out_if.hit, out_if.overflow);
          errors++;
        end else begin
          want_rsp = pending_results.pop_front();
          if (out_if.vaddr !== want_rsp.vaddr) begin
            $error("vaddr: expected %h, got %h", want_rsp.vaddr, out_if.vaddr);
            errors++;
          end
          if (out_if.hit !== want_rsp.hit) begin
            $error("hit: expected %b, got %b", want_rsp.hit, out_if.hit);
            errors++;
          end
          if (out_if.overflow !== want_rsp.overflow) begin
            $error("overflow: expected %b, got %b", want_rsp.overflow, out_if.overflow);
            errors++;
          end
        end
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Receiver: a long hold-off when a test asks for one, otherwise a stall pattern
  // that is redrawn at random from time to time (always ready, alternating, coin flip,
  // or mostly stalled).
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_if.ready = 1'b0;
      hold_cycles--;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 150);
      end
      rx_mode_left--;
      rx_toggle = !rx_toggle;
      case (rx_mode)
        0: out_if.ready = 1'b1;
        1: out_if.ready = rx_toggle;
        2: out_if.ready = 1'($urandom_range(0, 1));
        default: out_if.ready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  function automatic xlate_req_t make_req(input logic [sot_pkg::FuncW-1:0] func,
                                          input logic [31:0] seg_type,
                                          input logic [63:0] seg_offset,
                                          input logic [63:0] seg_filesz,
                                          input logic [63:0] seg_vaddr,
                                          input logic [63:0] file_offset);
    xlate_req_t req;
    req.func        = func;
    req.seg_type    = seg_type;
    req.seg_offset  = seg_offset;
    req.seg_filesz  = seg_filesz;
    req.seg_vaddr   = seg_vaddr;
    req.file_offset = file_offset;
    return req;
  endfunction

  // Offers one item from a falling edge and returns at the falling edge after it
  // is accepted. Valid stays high into the next item unless the burst has ended,
  // in which case the sender drops valid and goes quiet before the next item.
  task automatic send_item(input xlate_req_t req);
    in_if.valid       = 1'b1;
    in_if.func        = req.func;
    in_if.seg_type    = req.seg_type;
    in_if.seg_offset  = req.seg_offset;
    in_if.seg_filesz  = req.seg_filesz;
    in_if.seg_vaddr   = req.seg_vaddr;
    in_if.file_offset = req.file_offset;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (!(req.func == FUNC_UNUSED ||
          (req.func == sot_pkg::FUNC_ADD && req.seg_type != sot_pkg::LOADABLE_TYPE)))
      useful_items++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !gapless) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
  endtask

  task automatic clear_segments();
    send_item(make_req(sot_pkg::FUNC_CLEAR, '0, '0, '0, '0, '0));
  endtask

  task automatic add_segment(input logic [63:0] offs, input logic [63:0] size,
                             input logic [63:0] va);
    send_item(make_req(sot_pkg::FUNC_ADD, sot_pkg::LOADABLE_TYPE, offs, size, va, '0));
  endtask

  task automatic lookup(input logic [63:0] offs);
    send_item(make_req(sot_pkg::FUNC_XLATE, '0, '0, '0, '0, offs));
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic drain();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // The image base is only written while the block has nothing in flight.
  task automatic write_image_base(input logic [63:0] value);
    drain();
    cfg_if.valid      = 1'b1;
    cfg_if.image_base = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Hand-picked cases: zero base, ignored types and function code, range edges,
  // a wrapped segment, overlap resolution, a full table and a wrapping sum.
  task automatic test_directed();
    // Translate with an empty table and the reset base of zero.
    lookup(64'h1100);
    clear_segments();
    send_item(make_req(sot_pkg::FUNC_ADD, 32'd0, 64'h1000, 64'h200, 64'h40_0000, '0));
    send_item(make_req(sot_pkg::FUNC_ADD, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES,
                       ALL_ONES));
    add_segment(64'h1000, 64'h200, 64'h40_0000);
    // Zero base disables translation even though the offset is mapped.
    lookup(64'h1100);
    write_image_base(64'h0000_5555_0000_0000);
    lookup(64'h1000);
    lookup(64'h11FF);
    lookup(64'h1200);
    lookup(64'h0FFF);
    send_item(make_req(FUNC_UNUSED, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
    // This segment's end wraps past zero, so it must never match.
    add_segment(64'hFFFF_FFFF_FFFF_FF00, 64'h200, 64'h1234_0000);
    // Overlaps the first segment; the earlier entry wins where both match.
    add_segment(64'h1100, 64'h1000, 64'h9000);
    lookup(64'hFFFF_FFFF_FFFF_FF10);
    lookup(64'h1150);
    lookup(64'h2000);
    for (int unsigned i = 3; i < NUM_SEGS - 1; i++)
      add_segment(64'h10_0000 + 64'(i) * 64'h1000, 64'h800, 64'(i) << 32);
    // The last slot holds the top of the offset space and an address that wraps the sum.
    add_segment(64'hFFFF_FFFF_FFFF_FFFE, 64'd1, ALL_ONES);
    add_segment(64'h0, 64'h10, 64'h0);
    send_item(make_req(sot_pkg::FUNC_ADD, 32'd2, 64'h0, 64'h10, 64'h0, '0));
    lookup(64'hFFFF_FFFF_FFFF_FFFE);
    lookup(ALL_ONES);
    clear_segments();
    lookup(64'h1100);
    drain();
  endtask

  // Runs a small table through each extreme of the image base.
  task automatic test_base_sweep();
    logic [63:0] bases [4];
    bases[0] = ALL_ONES;
    bases[1] = 64'd1;
    bases[2] = 64'd0;
    bases[3] = rand64();
    foreach (bases[k]) begin
      write_image_base(bases[k]);
      clear_segments();
      add_segment(64'h8000, 64'h100, ALL_ONES - 64'h80);
      lookup(64'h80FF);
      lookup(64'h8000);
    end
    drain();
  endtask

  // Holds the receiver off for a long stretch while items keep coming, so the
  // output register and the finished result fill up and the input stalls.
  task automatic test_backpressure();
    write_image_base(64'h0000_7000_0000_0000);
    hold_cycles = 300;
    gapless     = 1'b1;
    clear_segments();
    for (int unsigned i = 0; i < 6; i++)
      add_segment(64'(i) * 64'h400, 64'h400, 64'h1_0000 * 64'(i + 1));
    for (int unsigned i = 0; i < 16; i++)
      lookup(64'($urandom_range(0, 'h1A00)));
    gapless = 1'b0;
    drain();
  endtask

  // Mostly well-formed programs: clear, a run of adds (sometimes past the table
  // size), then translates aimed inside, at the edges of, or away from the
  // segments just added. The rest is noise with random fields, the type loadable half the time.
  task automatic test_random();
    logic [63:0] lo_q[$];
    logic [63:0] sz_q[$];
    logic [63:0] offs;
    logic [63:0] size;
    logic [63:0] pick_lo;
    logic [63:0] pick_sz;
    logic [31:0] rnd_word;
    int unsigned n_adds;
    int unsigned n_looks;
    int unsigned j;
    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: write_image_base(64'd0);
          1: write_image_base(ALL_ONES);
          2: write_image_base(64'd1);
          default: write_image_base(rand64());
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 8)) begin
          rnd_word = $urandom();
          send_item(make_req(rnd_word[sot_pkg::FuncW-1:0],
                             ($urandom_range(0, 1) == 0) ? sot_pkg::LOADABLE_TYPE
                                                          : $urandom(),
                             rand64(), rand64(), rand64(), rand64()));
        end
      end else begin
        lo_q.delete();
        sz_q.delete();
        clear_segments();
        n_adds = $urandom_range(1, 18);
        for (int unsigned i = 0; i < n_adds; i++) begin
          offs = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 'hFFFF));
          case ($urandom_range(0, 9))
            0: size = 64'd0;
            1: size = rand64();
            default: size = 64'($urandom_range(1, 'h800));
          endcase
          if ($urandom_range(0, 9) == 0)
            send_item(make_req(sot_pkg::FUNC_ADD, $urandom(), offs, size, rand64(),
                               rand64()));
          else begin
            add_segment(offs, size, rand64());
            lo_q.push_back(offs);
            sz_q.push_back(size);
          end
        end
        n_looks = $urandom_range(3, 12);
        for (int unsigned i = 0; i < n_looks; i++) begin
          if (lo_q.size() == 0) begin
            lookup(rand64());
          end else begin
            j       = $urandom_range(0, lo_q.size() - 1);
            pick_lo = lo_q[j];
            pick_sz = sz_q[j];
            case ($urandom_range(0, 9))
              0: lookup(pick_lo + pick_sz);
              1: lookup(pick_lo - 64'd1);
              2: lookup(pick_lo + pick_sz - 64'd1);
              3: lookup(rand64());
              default: lookup((pick_sz == 0) ? pick_lo : pick_lo + (rand64() % pick_sz));
            endcase
          end
        end
      end
    end
    drain();
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = sot_pkg::FUNC_CLEAR;
    in_if.seg_type    = '0;
    in_if.seg_offset  = '0;
    in_if.seg_filesz  = '0;
    in_if.seg_vaddr   = '0;
    in_if.file_offset = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.image_base = '0;
    out_if.ready      = 1'b0;
    seg_fill          = 0;
    load_base         = '0;
    errors            = 0;
    useful_items      = 0;
    quiet_cycles      = 0;
    burst_left        = 4;
    gapless           = 1'b0;
    hold_cycles       = 0;
    rx_mode           = 0;
    rx_mode_left      = 0;
    rx_toggle         = 1'b0;

    // Reset is asserted at the start and released at a falling edge.
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_base_sweep();
    test_backpressure();
    test_random();

    // Nothing is outstanding now; give a stray extra result time to show up.
    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- segment_offset_translator_unit.f -----
rtl/core/sot_pkg.sv
rtl/core/sot_in_if.sv
rtl/core/sot_out_if.sv
rtl/core/sot_cfg_if.sv
rtl/core/sot_ctrl.sv
rtl/core/sot_dp.sv
rtl/core/segment_offset_translator_unit.sv
dv/testbench.sv
